/* design/fas_pkg.sv */
// Shared types and constants of the frame animation sequencer.
package fas_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int FRAME_W    = 6;
	localparam int FCNT_W     = 7;
	localparam int TIME_W     = 16;
	localparam int ELAPSED_W  = 18;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int PADDR_W    = 3;

	localparam logic REG_LOOP = 1'b0;
	localparam logic REG_FCNT = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_START   = 3'd1,
		OP_PAUSE   = 3'd2,
		OP_RESUME  = 3'd3,
		OP_EXTRA   = 3'd4,
		OP_RESTART = 3'd5,
		OP_WRITE   = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		EV_ANIM_BEGIN  = 2'd0,
		EV_FRAME_BEGIN = 2'd1,
		EV_FRAME_END   = 2'd2,
		EV_ANIM_END    = 2'd3
	} ev_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TICK,
		S_RAB,
		S_RFB,
		S_AB,
		S_CFB,
		S_TFE,
		S_TAE,
		S_SFE,
		S_SAE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  arg;
		logic [FRAME_W-1:0] idx;
	} item_t;

	typedef struct packed {
		logic              loop_enable;
		logic [FCNT_W-1:0] frame_count;
	} cfg_t;

	typedef struct packed {
		ev_t                kind;
		logic [FRAME_W-1:0] frame;
		logic               last;
		logic               done;
		logic               hold;
	} res_t;

endpackage

/* design/fas_ram.sv */
// Generic simple dual-port RAM with a registered read.
module fas_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/fas_front.sv */
// Front end: accepts input items, decodes them and queues them for the back end.
module fas_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    operation,
	input  logic [fas_pkg::TIME_W-1:0]    time_step,
	input  logic [fas_pkg::FRAME_W-1:0]   frame_index,
	input  logic [fas_pkg::TIME_W-1:0]    delay_value,
	output logic                          q_valid,
	output fas_pkg::item_t                q_item,
	input  logic                          q_pop
);

	fas_pkg::item_t                q_mem_q [fas_pkg::QDEPTH];
	logic [fas_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [fas_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [fas_pkg::QCNT_W-1:0]    cnt_q;
	fas_pkg::item_t                dec_item;
	logic                          dec_keep;
	logic                          push;
	logic                          pop;

	// Code seven has no effect and is dropped here.
	always_comb begin
		dec_item.idx = frame_index;
		dec_item.arg = delay_value;
		dec_item.op  = fas_pkg::OP_TICK;
		dec_keep     = 1'b1;
		case (operation)
			fas_pkg::OP_TICK: begin
				dec_item.op  = fas_pkg::OP_TICK;
				dec_item.arg = time_step;
			end
			fas_pkg::OP_START:   dec_item.op = fas_pkg::OP_START;
			fas_pkg::OP_PAUSE:   dec_item.op = fas_pkg::OP_PAUSE;
			fas_pkg::OP_RESUME:  dec_item.op = fas_pkg::OP_RESUME;
			fas_pkg::OP_EXTRA:   dec_item.op = fas_pkg::OP_EXTRA;
			fas_pkg::OP_RESTART: dec_item.op = fas_pkg::OP_RESTART;
			fas_pkg::OP_WRITE:   dec_item.op = fas_pkg::OP_WRITE;
			default: dec_keep = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != fas_pkg::QCNT_W'(fas_pkg::QDEPTH));
	assign push     = in_valid && in_ready && dec_keep;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/fas_back.sv */
// Back end: sequencer state, delay table and the event output register.
module fas_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fas_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  fas_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output fas_pkg::res_t  res
);

	fas_pkg::state_t                 state_q, state_d;
	logic [fas_pkg::FRAME_W-1:0]     cf_q, cf_d;
	logic [fas_pkg::ELAPSED_W-1:0]   et_q, et_d;
	logic [fas_pkg::TIME_W-1:0]      extra_q, extra_d;
	logic                            paused_q, paused_d;
	logic                            fin_q, fin_d;
	logic                            sh_q, sh_d;
	logic                            rp_q, rp_d;
	logic                            hit_q, hit_d;
	logic [fas_pkg::TIME_W-1:0]      arg_q, arg_d;
	logic                            out_valid_q;
	fas_pkg::res_t                   res_q;

	logic                            ram_we;
	logic                            ram_re;
	logic [fas_pkg::FRAME_W-1:0]     ram_raddr;
	logic [fas_pkg::TIME_W-1:0]      ram_rdata;

	logic [fas_pkg::FCNT_W-1:0]      n_frames;
	logic                            is_last;
	logic                            out_free;
	logic                            ev_emit;
	fas_pkg::res_t                   ev;
	logic [fas_pkg::ELAPSED_W-1:0]   et_base;
	logic [fas_pkg::ELAPSED_W-1:0]   et_sum;
	logic [fas_pkg::TIME_W:0]        limit;
	logic                            run;
	logic                            hit;
	logic                            delay_zero;
	logic [fas_pkg::FRAME_W-1:0]     start_frame;

	fas_ram #(
		.WIDTH(fas_pkg::TIME_W),
		.DEPTH(fas_pkg::MAX_FRAMES)
	) u_delay_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_item.idx),
		.wdata(q_item.arg),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (cfg.frame_count == '0) begin
			n_frames = fas_pkg::FCNT_W'(1);
		end else if (cfg.frame_count > fas_pkg::FCNT_W'(fas_pkg::MAX_FRAMES)) begin
			n_frames = fas_pkg::FCNT_W'(fas_pkg::MAX_FRAMES);
		end else begin
			n_frames = cfg.frame_count;
		end
	end

	assign is_last     = !(({1'b0, cf_q} + fas_pkg::FCNT_W'(1)) < n_frames);
	assign start_frame = ({1'b0, q_item.idx} < n_frames) ? q_item.idx
	                     : fas_pkg::FRAME_W'(n_frames - fas_pkg::FCNT_W'(1));
	assign out_free    = !out_valid_q || out_ready;
	assign et_base     = rp_q ? '0 : et_q;
	assign et_sum      = et_base + {2'b00, arg_q};
	assign limit       = {1'b0, ram_rdata} + {1'b0, extra_q};
	assign run         = !(paused_q || fin_q || sh_q);
	assign hit         = run && (et_sum >= {1'b0, limit});
	assign delay_zero  = (ram_rdata == '0);

	always_comb begin
		state_d   = state_q;
		cf_d      = cf_q;
		et_d      = et_q;
		extra_d   = extra_q;
		paused_d  = paused_q;
		fin_d     = fin_q;
		sh_d      = sh_q;
		rp_d      = rp_q;
		hit_d     = hit_q;
		arg_d     = arg_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = cf_q;
		ev_emit   = 1'b0;
		ev.kind   = fas_pkg::EV_ANIM_BEGIN;
		ev.frame  = cf_q;
		ev.last   = 1'b0;
		ev.done   = fin_q;
		ev.hold   = sh_q;
		case (state_q)
			fas_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					arg_d = q_item.arg;
					case (q_item.op)
						fas_pkg::OP_TICK: begin
							ram_re    = 1'b1;
							ram_raddr = rp_q ? '0 : cf_q;
							state_d   = fas_pkg::S_TICK;
						end
						fas_pkg::OP_START: begin
							et_d     = '0;
							fin_d    = 1'b0;
							paused_d = 1'b0;
							sh_d     = 1'b0;
							rp_d     = 1'b0;
							cf_d     = start_frame;
							state_d  = fas_pkg::S_AB;
						end
						fas_pkg::OP_PAUSE: paused_d = 1'b1;
						fas_pkg::OP_RESUME: begin
							paused_d = 1'b0;
							if (sh_q) begin
								sh_d    = 1'b0;
								hit_d   = 1'b0;
								state_d = fas_pkg::S_RAB;
							end
						end
						fas_pkg::OP_EXTRA: extra_d = q_item.arg;
						fas_pkg::OP_RESTART: begin
							fin_d = 1'b0;
							rp_d  = 1'b1;
						end
						fas_pkg::OP_WRITE: begin
							ram_we = ({1'b0, q_item.idx} <
							          fas_pkg::FCNT_W'(fas_pkg::MAX_FRAMES));
						end
						default: ;
					endcase
				end
			end
			fas_pkg::S_TICK: begin
				rp_d  = 1'b0;
				hit_d = hit;
				if (rp_q) begin
					cf_d = '0;
				end
				et_d = run ? (hit ? '0 : et_sum) : et_base;
				if (hit) begin
					extra_d = '0;
				end
				if (rp_q) begin
					state_d = fas_pkg::S_RAB;
				end else if (hit) begin
					state_d = fas_pkg::S_TFE;
				end else begin
					state_d = fas_pkg::S_IDLE;
				end
			end
			fas_pkg::S_RAB: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_ANIM_BEGIN;
				if (out_free) begin
					state_d = fas_pkg::S_RFB;
				end
			end
			fas_pkg::S_RFB: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_FRAME_BEGIN;
				ev.last = !hit_q;
				if (out_free) begin
					state_d = hit_q ? fas_pkg::S_TFE : fas_pkg::S_IDLE;
				end
			end
			fas_pkg::S_AB: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_ANIM_BEGIN;
				ram_re  = 1'b1;
				if (out_free) begin
					state_d = fas_pkg::S_CFB;
				end
			end
			fas_pkg::S_CFB: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_FRAME_BEGIN;
				ev.last = !delay_zero;
				if (out_free) begin
					state_d = delay_zero ? fas_pkg::S_SFE : fas_pkg::S_IDLE;
				end
			end
			fas_pkg::S_TFE: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_FRAME_END;
				if (out_free) begin
					if (!is_last) begin
						cf_d      = cf_q + 1'b1;
						ram_re    = 1'b1;
						ram_raddr = cf_q + 1'b1;
						state_d   = fas_pkg::S_CFB;
					end else begin
						state_d = fas_pkg::S_TAE;
					end
				end
			end
			fas_pkg::S_TAE: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_ANIM_END;
				ev.done = fin_q || !cfg.loop_enable;
				ev.last = !cfg.loop_enable;
				if (out_free) begin
					fin_d = fin_q || !cfg.loop_enable;
					if (cfg.loop_enable) begin
						cf_d    = '0;
						state_d = fas_pkg::S_AB;
					end else begin
						state_d = fas_pkg::S_IDLE;
					end
				end
			end
			fas_pkg::S_SFE: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_FRAME_END;
				ev.hold = 1'b1;
				ev.last = !is_last;
				if (out_free) begin
					sh_d = 1'b1;
					if (!is_last) begin
						cf_d    = cf_q + 1'b1;
						state_d = fas_pkg::S_IDLE;
					end else begin
						state_d = fas_pkg::S_SAE;
					end
				end
			end
			fas_pkg::S_SAE: begin
				ev_emit = 1'b1;
				ev.kind = fas_pkg::EV_ANIM_END;
				ev.done = fin_q || !cfg.loop_enable;
				ev.last = 1'b1;
				if (out_free) begin
					fin_d = fin_q || !cfg.loop_enable;
					if (cfg.loop_enable) begin
						cf_d = '0;
					end
					state_d = fas_pkg::S_IDLE;
				end
			end
			default: state_d = fas_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		arg_q <= arg_d;
		if (ev_emit && out_free) begin
			res_q <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fas_pkg::S_IDLE;
			cf_q        <= '0;
			et_q        <= '0;
			extra_q     <= '0;
			paused_q    <= 1'b0;
			fin_q       <= 1'b0;
			sh_q        <= 1'b0;
			rp_q        <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cf_q     <= cf_d;
			et_q     <= et_d;
			extra_q  <= extra_d;
			paused_q <= paused_d;
			fin_q    <= fin_d;
			sh_q     <= sh_d;
			rp_q     <= rp_d;
			hit_q    <= hit_d;
			if (ev_emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_ram_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("Delay table written and read in the same cycle.");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_emit && out_free && ev.last) |=> (state_q == fas_pkg::S_IDLE))
		else $error("Sequence continued after its final event.");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_emit && out_free && !ev.last) |=> (state_q != fas_pkg::S_IDLE))
		else $error("Sequence ended on an event not marked final.");

	a_read_before_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fas_pkg::S_CFB && $past(state_q) != fas_pkg::S_CFB) |->
		$past(ram_re))
		else $error("Stop frame check without a fresh delay read.");

	a_restart_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!(fin_q && rp_q))
		else $error("Finished and restart pending both set.");

endmodule

/* design/frame_animation_sequencer_unit.sv */
// Top level of the frame animation sequencer: configuration registers and the two ends.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    operation, time_step, frame_index, delay_value
// out       output     out_valid/out_ready  event_res, event_frame, last, done_flag, hold_flag
// apb       input      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// Items enter a four-deep queue at one a cycle while it is not full; the back end takes a
// new item only once it is idle again, after the events of the last one are sent.
// The delay table is read while the event before a frame check is sent.
// Reset clears the sequencer state and the queue; the delay table is not cleared.
// A stalled output holds the sequencer while the queue keeps taking items until it is full.
module frame_animation_sequencer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fas_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    operation,
	input  logic [15:0]                   time_step,
	input  logic [5:0]                    frame_index,
	input  logic [15:0]                   delay_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    event_res,
	output logic [5:0]                    event_frame,
	output logic                          last,
	output logic                          done_flag,
	output logic                          hold_flag
);

	logic                          loop_q;
	logic [fas_pkg::FCNT_W-1:0]    fcnt_q;
	fas_pkg::cfg_t                 cfg;
	logic                          q_valid;
	fas_pkg::item_t                q_item;
	logic                          q_pop;
	fas_pkg::res_t                 res;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
			fcnt_q <= fas_pkg::FCNT_W'(1);
		end else if (wr_en) begin
			case (paddr[2])
				fas_pkg::REG_LOOP: loop_q <= pwdata[0];
				fas_pkg::REG_FCNT: fcnt_q <= pwdata[fas_pkg::FCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			fas_pkg::REG_LOOP: prdata = {31'd0, loop_q};
			fas_pkg::REG_FCNT: prdata = {{(32 - fas_pkg::FCNT_W){1'b0}}, fcnt_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.loop_enable = loop_q;
	assign cfg.frame_count = fcnt_q;

	fas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.time_step  (time_step),
		.frame_index(frame_index),
		.delay_value(delay_value),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	fas_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign event_res   = res.kind;
	assign event_frame = res.frame;
	assign last        = res.last;
	assign done_flag   = res.done;
	assign hold_flag   = res.hold;

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the frame animation sequencer with an event scoreboard.
`timescale 1ns / 100ps

module testbench;

	localparam bit [2:0] OP_UNUSED = 3'd7;
	localparam logic [fas_pkg::PADDR_W-1:0] ADDR_LOOP = {fas_pkg::REG_LOOP, 2'b00};
	localparam logic [fas_pkg::PADDR_W-1:0] ADDR_COUNT = {fas_pkg::REG_FCNT, 2'b00};
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS = 220;
	localparam int LONG_HOLD = 400;

	class event_board;
		bit [15:0] delays[fas_pkg::MAX_FRAMES];
		bit [5:0] frame;
		bit [17:0] elapsed;
		bit [15:0] extra;
		bit paused, finished, held, restart_due;
		bit loop_on;
		bit [6:0] count_reg = 7'd1;
		fas_pkg::res_t batch[$];
		fas_pkg::res_t due[$];
		int misses;

		function int frames_used();
			if (count_reg == 0) return 1;
			if (count_reg > fas_pkg::MAX_FRAMES) return fas_pkg::MAX_FRAMES;
			return int'(count_reg);
		endfunction

		function bit at_last();
			return !(int'(frame) + 1 < frames_used());
		endfunction

		function void post(fas_pkg::ev_t kind);
			fas_pkg::res_t r;
			if (batch.size() >= 8) return;
			r.kind = kind;
			r.frame = frame;
			r.last = 1'b0;
			r.done = finished;
			r.hold = held;
			batch.push_back(r);
		endfunction

		// A frame with no delay ends at once and holds the animation.
		function void check_stop_frame();
			if (delays[frame] != 0) return;
			held = 1'b1;
			post(fas_pkg::EV_FRAME_END);
			if (!at_last()) begin
				frame++;
				return;
			end
			if (!loop_on) finished = 1'b1;
			post(fas_pkg::EV_ANIM_END);
			if (loop_on) frame = 6'd0;
		endfunction

		function void advance_time(bit [15:0] step);
			bit [17:0] span;
			if (restart_due) begin
				frame = 6'd0;
				elapsed = 18'd0;
				restart_due = 1'b0;
				post(fas_pkg::EV_ANIM_BEGIN);
				post(fas_pkg::EV_FRAME_BEGIN);
			end
			if (paused || finished || held) return;
			elapsed = elapsed + 18'(step);
			span = 18'(delays[frame]) + 18'(extra);
			if (elapsed < span) return;
			post(fas_pkg::EV_FRAME_END);
			elapsed = 18'd0;
			extra = 16'd0;
			if (!at_last()) begin
				frame++;
				post(fas_pkg::EV_FRAME_BEGIN);
				check_stop_frame();
				return;
			end
			if (!loop_on) finished = 1'b1;
			post(fas_pkg::EV_ANIM_END);
			if (loop_on) begin
				frame = 6'd0;
				post(fas_pkg::EV_ANIM_BEGIN);
				post(fas_pkg::EV_FRAME_BEGIN);
				check_stop_frame();
			end
		endfunction

		function void take_item(bit [2:0] op, bit [15:0] step, bit [5:0] idx,
				bit [15:0] val);
			fas_pkg::res_t r;
			int n;
			batch.delete();
			case (op)
				fas_pkg::OP_TICK: advance_time(step);
				fas_pkg::OP_START: begin
					n = frames_used();
					elapsed = 18'd0;
					finished = 1'b0;
					paused = 1'b0;
					held = 1'b0;
					restart_due = 1'b0;
					frame = (int'(idx) < n) ? idx : 6'(n - 1);
					post(fas_pkg::EV_ANIM_BEGIN);
					post(fas_pkg::EV_FRAME_BEGIN);
					check_stop_frame();
				end
				fas_pkg::OP_PAUSE: paused = 1'b1;
				fas_pkg::OP_RESUME: begin
					paused = 1'b0;
					if (held) begin
						held = 1'b0;
						post(fas_pkg::EV_ANIM_BEGIN);
						post(fas_pkg::EV_FRAME_BEGIN);
					end
				end
				fas_pkg::OP_EXTRA: extra = val;
				fas_pkg::OP_RESTART: begin
					finished = 1'b0;
					restart_due = 1'b1;
				end
				fas_pkg::OP_WRITE: delays[idx] = val;
				default: ;
			endcase
			foreach (batch[i]) begin
				r = batch[i];
				r.last = (i == batch.size() - 1);
				due.push_back(r);
			end
		endfunction

		function void note_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s differs, expected %0d, actual %0d", $time, name, want, got);
				misses++;
			end
		endfunction

		function void match_event(fas_pkg::res_t got);
			fas_pkg::res_t want;
			if (due.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual kind %0d frame %0d",
					$time, got.kind, got.frame);
				misses++;
				return;
			end
			want = due.pop_front();
			note_field("event_res", want.kind, got.kind);
			note_field("event_frame", want.frame, got.frame);
			note_field("last", want.last, got.last);
			note_field("done_flag", want.done, got.done);
			note_field("hold_flag", want.hold, got.hold);
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [fas_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [15:0] time_step = '0;
	logic [5:0] frame_index = '0;
	logic [15:0] delay_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] event_res;
	logic [5:0] event_frame;
	logic last;
	logic done_flag;
	logic hold_flag;

	event_board board = new;
	bit send_quiet, recv_quiet;
	int long_hold;
	int items_sent;

	frame_animation_sequencer_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .time_step(time_step),
		.frame_index(frame_index), .delay_value(delay_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_res(event_res), .event_frame(event_frame), .last(last),
		.done_flag(done_flag), .hold_flag(hold_flag)
	);

	always #1 clk = ~clk;

	task automatic send_item(input bit [2:0] op, input bit [15:0] step, input bit [5:0] idx,
			input bit [15:0] val);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		time_step <= step;
		frame_index <= idx;
		delay_value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.take_item(op, step, idx, val);
		if (op != OP_UNUSED) items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [fas_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input bit loop_on, input bit [6:0] count);
		settle();
		apb_write(ADDR_LOOP, {31'd0, loop_on});
		apb_write(ADDR_COUNT, {25'd0, count});
		board.loop_on = loop_on;
		board.count_reg = count;
	endtask

	function automatic bit [15:0] rand_delay();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'($urandom);
			default: return 16'($urandom_range(1, 10));
		endcase
	endfunction

	function automatic bit [6:0] rand_count();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd127;
			2: return 7'd64;
			default: return 7'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic random_item();
		bit [2:0] op;
		bit [15:0] step, val;
		bit [5:0] idx;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 66) op = fas_pkg::OP_TICK;
		else if (pick < 72) op = fas_pkg::OP_PAUSE;
		else if (pick < 80) op = fas_pkg::OP_RESUME;
		else if (pick < 85) op = fas_pkg::OP_EXTRA;
		else if (pick < 90) op = fas_pkg::OP_RESTART;
		else if (pick < 96) op = fas_pkg::OP_WRITE;
		else if (pick < 98) op = fas_pkg::OP_START;
		else op = OP_UNUSED;
		step = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		idx = 6'($urandom);
		val = 16'($urandom);
		if (op == fas_pkg::OP_WRITE) begin
			if ($urandom_range(0, 9) < 7) idx = 6'($urandom_range(0, board.frames_used() - 1));
			val = rand_delay();
		end else if (op == fas_pkg::OP_EXTRA && $urandom_range(0, 3) != 0) begin
			val = 16'($urandom_range(0, 8));
		end
		send_item(op, step, idx, val);
	endtask

	initial begin
		int target;
		int phase;
		int body;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < fas_pkg::MAX_FRAMES; i++)
			send_item(fas_pkg::OP_WRITE, 16'($urandom), 6'(i), rand_delay());

		configure(1'b0, 7'd1);
		send_item(fas_pkg::OP_WRITE, 16'd0, 6'd0, 16'd3);
		send_item(fas_pkg::OP_START, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_TICK, 16'hFFFF, 6'd0, 16'd0);
		send_item(fas_pkg::OP_TICK, 16'd5, 6'd0, 16'd0);
		send_item(fas_pkg::OP_RESTART, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_TICK, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_PAUSE, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_TICK, 16'hFFFF, 6'd0, 16'd0);
		send_item(fas_pkg::OP_RESUME, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_EXTRA, 16'd0, 6'd0, 16'hFFFF);
		send_item(fas_pkg::OP_TICK, 16'hFFFF, 6'd0, 16'd0);
		send_item(fas_pkg::OP_TICK, 16'hFFFF, 6'd0, 16'd0);

		configure(1'b1, 7'd64);
		send_item(fas_pkg::OP_WRITE, 16'd0, 6'd63, 16'd0);
		send_item(fas_pkg::OP_START, 16'd0, 6'd63, 16'd0);
		send_item(fas_pkg::OP_RESUME, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_WRITE, 16'd0, 6'd5, 16'd0);
		send_item(fas_pkg::OP_WRITE, 16'd0, 6'd4, 16'd1);
		send_item(fas_pkg::OP_START, 16'd0, 6'd4, 16'd0);
		send_item(fas_pkg::OP_TICK, 16'd1, 6'd0, 16'd0);
		send_item(fas_pkg::OP_RESUME, 16'd0, 6'd0, 16'd0);
		send_item(OP_UNUSED, 16'hFFFF, 6'd63, 16'hFFFF);

		configure(1'b1, 7'd1);
		send_item(fas_pkg::OP_WRITE, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_START, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_RESUME, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_RESTART, 16'd0, 6'd0, 16'd0);
		send_item(fas_pkg::OP_TICK, 16'd0, 6'd0, 16'd0);

		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			configure(1'($urandom), rand_count());
			send_quiet = ($urandom_range(0, 3) == 0);
			recv_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				send_quiet = 1'b1;
				recv_quiet = 1'b0;
				long_hold = LONG_HOLD;
			end
			repeat ($urandom_range(1, 4))
				send_item(fas_pkg::OP_WRITE, 16'($urandom),
					6'($urandom_range(0, board.frames_used() - 1)), rand_delay());
			if ($urandom_range(0, 5) != 0)
				send_item(fas_pkg::OP_START, 16'($urandom), 6'($urandom), 16'($urandom));
			body = $urandom_range(15, 35);
			repeat (body) random_item();
			phase++;
		end

		settle();
		if (board.misses == 0)
			$display("frame_animation_sequencer_unit: match");
		else
			$display("frame_animation_sequencer_unit: mismatch");
		$finish;
	end

	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = recv_quiet ? 0 : $urandom_range(0, 18);
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			board.match_event(fas_pkg::res_t'{kind: fas_pkg::ev_t'(event_res),
				frame: event_frame, last: last, done: done_flag, hold: hold_flag});
		end
	end

	initial begin
		#1_000_000;
		$display("frame_animation_sequencer_unit: mismatch");
		$finish;
	end

endmodule
